>>> hw/rtl/lsbse_pkg.sv
`default_nettype none

package lsbse_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned BYTES_W = 26;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 26;

    localparam logic [CNT_W-1:0] BYTE_BITS = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BPC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_COVER = 1'b1;

    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    localparam logic [1:0] OT_STEGO   = 2'd0;
    localparam logic [1:0] OT_PAYLOAD = 2'd1;
    localparam logic [1:0] OT_REFUSED = 2'd2;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] cover_byte;
        logic              cover_last;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [1:0]        out_type;
        logic              overflow;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]   bpc;
        logic               mode;
        logic [BYTES_W-1:0] byte_count;
    } t_cfg;

    // Low-bit mask of width n, n in 1..8
    function automatic logic [BYTE_W-1:0] f_low_mask(input logic [CNT_W-1:0] n);
        f_low_mask = 8'hFF >> (BYTE_BITS - n);
    endfunction

    function automatic logic [CNT_W-1:0] f_min(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
        f_min = (a < b) ? a : b;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lsbse_in_if.sv
`default_nettype none

interface lsbse_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] cover_byte;
    logic       cover_last;

    modport source (output valid, kind, payload_byte, cover_byte, cover_last,
                    input ready);
    modport sink   (input valid, kind, payload_byte, cover_byte, cover_last,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lsbse_out_if.sv
`default_nettype none

interface lsbse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] out_type;
    logic       overflow;

    modport source (output valid, out_byte, out_type, overflow, input ready);
    modport sink   (input valid, out_byte, out_type, overflow, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lsbse_cfg.sv
`default_nettype none

module lsbse_cfg import lsbse_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                       o_cfg,
    output logic                       o_clear
);

    logic [CNT_W-1:0]   r_bpc;
    logic               r_mode;
    logic [BYTES_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpc   <= 4'd1;
            r_mode  <= MODE_EMBED;
            r_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BPC:   r_bpc   <= i_cfg_wdata[CNT_W-1:0];
                REG_MODE:  r_mode  <= i_cfg_wdata[0];
                REG_COUNT: r_count <= i_cfg_wdata[BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    // Any write to a defined register restarts the run
    assign o_clear = i_cfg_we && (i_cfg_idx == REG_BPC || i_cfg_idx == REG_MODE ||
                                  i_cfg_idx == REG_COUNT);

    always_comb begin
        o_cfg.mode       = r_mode;
        o_cfg.byte_count = r_count;
        if (r_bpc == 4'd0) begin
            o_cfg.bpc = 4'd1;
        end else if (r_bpc > BYTE_BITS) begin
            o_cfg.bpc = BYTE_BITS;
        end else begin
            o_cfg.bpc = r_bpc;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lsbse_core.sv
`default_nettype none

module lsbse_core import lsbse_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_clear,
    input  wire logic  i_valid,
    input  wire logic  i_fire,
    input  wire t_item i_item,
    output logic       o_has_result,
    output t_result    o_result
);

    logic [BYTE_W-1:0]  r_pending, n_pending;
    logic [CNT_W-1:0]   r_bits_left, n_bits_left;
    logic [BYTE_W-1:0]  r_gathered, n_gathered;
    logic [CNT_W-1:0]   r_bits_gath, n_bits_gath;
    logic [BYTES_W-1:0] r_bytes_done, n_bytes_done;

    logic               count_open;
    logic [CNT_W-1:0]   emb_n;
    logic [BYTE_W-1:0]  emb_mask;
    logic [BYTE_W-1:0]  emb_chunk;
    logic [CNT_W-1:0]   emb_left;
    logic [BYTES_W-1:0] emb_done;
    logic [CNT_W-1:0]   ext_n;
    logic [BYTE_W-1:0]  ext_mask;
    logic [2*BYTE_W-1:0] ext_shift;
    logic [BYTE_W-1:0]  ext_byte;
    logic [CNT_W-1:0]   ext_cnt;

    assign count_open = r_bytes_done < i_cfg.byte_count;

    // Embed datapath
    assign emb_n     = f_min(r_bits_left, i_cfg.bpc);
    assign emb_mask  = f_low_mask(emb_n);
    assign emb_chunk = (r_pending >> (r_bits_left - emb_n)) & emb_mask;
    assign emb_left  = r_bits_left - emb_n;
    assign emb_done  = r_bytes_done + BYTES_W'(emb_left == '0 && count_open);

    // Extract datapath
    assign ext_n     = f_min(BYTE_BITS - r_bits_gath, i_cfg.bpc);
    assign ext_mask  = f_low_mask(ext_n);
    assign ext_shift = {{BYTE_W{1'b0}}, r_gathered} << ext_n;
    assign ext_byte  = ext_shift[BYTE_W-1:0] | (i_item.cover_byte & ext_mask);
    assign ext_cnt   = r_bits_gath + ext_n;

    always_comb begin
        n_pending    = r_pending;
        n_bits_left  = r_bits_left;
        n_gathered   = r_gathered;
        n_bits_gath  = r_bits_gath;
        n_bytes_done = r_bytes_done;
        o_has_result = 1'b0;
        o_result     = '{out_byte: '0, out_type: OT_STEGO, overflow: 1'b0};

        if (i_item.kind == KIND_LOAD) begin
            if (i_cfg.mode == MODE_EMBED && r_bits_left == '0 && count_open) begin
                n_pending   = i_item.payload_byte;
                n_bits_left = BYTE_BITS;
            end else begin
                o_has_result      = 1'b1;
                o_result.out_type = OT_REFUSED;
            end
        end else if (i_cfg.mode == MODE_EMBED) begin
            o_has_result      = 1'b1;
            o_result.out_type = OT_STEGO;
            if (r_bits_left != '0) begin
                o_result.out_byte = (i_item.cover_byte & ~emb_mask) | emb_chunk;
                n_bits_left       = emb_left;
                n_bytes_done      = emb_done;
                o_result.overflow = i_item.cover_last &&
                                    (emb_left != '0 || emb_done < i_cfg.byte_count);
            end else begin
                o_result.out_byte = i_item.cover_byte;
                o_result.overflow = i_item.cover_last && count_open;
            end
        end else if (count_open) begin
            n_gathered  = ext_byte;
            n_bits_gath = ext_cnt;
            if (ext_cnt >= BYTE_BITS || i_item.cover_last) begin
                o_has_result      = 1'b1;
                o_result.out_type = OT_PAYLOAD;
                o_result.out_byte = ext_byte;
                n_bytes_done      = r_bytes_done + BYTES_W'(1);
                n_gathered        = '0;
                n_bits_gath       = '0;
            end
        end

        // Last cover byte ends the run
        if (i_item.kind == KIND_COVER && i_item.cover_last) begin
            n_pending    = '0;
            n_bits_left  = '0;
            n_gathered   = '0;
            n_bits_gath  = '0;
            n_bytes_done = '0;
        end

        if (!i_valid) begin
            o_has_result = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_pending    <= '0;
            r_bits_left  <= '0;
            r_gathered   <= '0;
            r_bits_gath  <= '0;
            r_bytes_done <= '0;
        end else if (i_fire) begin
            r_pending    <= n_pending;
            r_bits_left  <= n_bits_left;
            r_gathered   <= n_gathered;
            r_bits_gath  <= n_bits_gath;
            r_bytes_done <= n_bytes_done;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lsbse_out_reg.sv
`default_nettype none

module lsbse_out_reg import lsbse_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    output logic         o_free,
    lsbse_out_if.source  o_out
);

    logic    r_valid;
    t_result r_result;

    // Free when empty or the held beat leaves this cycle
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_result.out_byte;
    assign o_out.out_type = r_result.out_type;
    assign o_out.overflow = r_result.overflow;

endmodule

`default_nettype wire

>>> hw/rtl/lsb_stego_embed_extract.sv
`default_nettype none

// LSB steganography stream block. Each input beat is either a payload byte to
// load (embed mode) or a cover byte; cover bytes come back as stego bytes in
// embed mode, or feed recovered payload bytes in extract mode, using the low
// bits_per_channel bits of each cover byte, most significant chunk first.
// One beat is taken every clock cycle while the receiver keeps up; a beat
// passes an input register and then the result register, which presents its
// result on the output. The run state is read and updated in the one step
// between the two registers, which is what sets the one-per-cycle figure.
// Write configuration only while the block is idle; any write to a defined
// register restarts the run, as does a cover byte marked last.
module lsb_stego_embed_extract import lsbse_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    lsbse_in_if.sink                   i_in,
    lsbse_out_if.source                o_out
);

    t_cfg    cfg;
    logic    cfg_clear;
    logic    r_in_valid;
    t_item   r_item;
    logic    has_result;
    t_result result;
    logic    out_free;
    logic    advance;

    lsbse_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg),
        .o_clear     (cfg_clear)
    );

    // Hold the registered beat only if it makes a result and the output register is not free
    assign advance    = r_in_valid && (!has_result || out_free);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item.kind         <= i_in.kind;
            r_item.payload_byte <= i_in.payload_byte;
            r_item.cover_byte   <= i_in.cover_byte;
            r_item.cover_last   <= i_in.cover_last;
        end
    end

    lsbse_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_clear      (cfg_clear),
        .i_valid      (r_in_valid),
        .i_fire       (advance),
        .i_item       (r_item),
        .o_has_result (has_result),
        .o_result     (result)
    );

    lsbse_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && has_result),
        .i_result (result),
        .o_free   (out_free),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire
